// ----- design/mbh_pkg.sv -----
`default_nettype none
package mbh_pkg;

   localparam int unsigned GridWDefault = 512;
   localparam int unsigned GridHDefault = 512;
   localparam int unsigned Frac         = 28;
   localparam int unsigned CsrIdxW      = 3;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_LEFT   = 3'd0,
      CSR_RIGHT  = 3'd1,
      CSR_BOTTOM = 3'd2,
      CSR_TOP    = 3'd3,
      CSR_XSCALE = 3'd4,
      CSR_YSCALE = 3'd5,
      CSR_MAXIT  = 3'd6
   } csr_idx_type;

   localparam logic CMD_ITER = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] c_re;
      logic signed [31:0] c_im;
      logic [8:0]         cell_col;
      logic [8:0]         cell_row;
   } req_type;

   typedef struct packed {
      logic [16:0]        steps;
      logic               escaped;
      logic [31:0]        hit_count;
      logic signed [31:0] last_re;
      logic signed [31:0] last_im;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] left_bound;
      logic signed [31:0] right_bound;
      logic signed [31:0] bottom_bound;
      logic signed [31:0] top_bound;
      logic [31:0]        x_scale;
      logic [31:0]        y_scale;
      logic [15:0]        max_iter;
   } cfg_type;

   // one 33x33 signed product, shared unit operand selects
   typedef enum logic [2:0] {
      MUL_RR, MUL_II, MUL_RI, MUL_X, MUL_Y
   } mul_op_type;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647)       r = 32'sh7FFFFFFF;
      else if (v < -40'sd2147483648) r = 32'sh80000000;
      else                           r = v[31:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- design/mandelbrot_orbit_histogram.sv -----
`default_nettype none
// channel | direction | handshake              | payload
// req     | in        | start & !busy          | mbh_pkg::req_type
// rsp     | out       | rsp_valid, one cycle   | mbh_pkg::rsp_type
// csr     | in        | csr_valid & csr_ready  | csr_index, csr_wdata
// After reset a clearing pass writes every cell, with busy high.
// Point: each step runs through one shared multiplier (re^2, im^2, re*im,
// check, window test), plus the window path when z hits the window (two index products,
// row capture, read, write), and a final check; up to max_iter+1 steps.
// A cell read goes through S_RD and S_RD2. Results are never stalled: rsp_valid marks one cycle.
module mandelbrot_orbit_histogram #(
   parameter int unsigned GRID_W = mbh_pkg::GridWDefault,
   parameter int unsigned GRID_H = mbh_pkg::GridHDefault
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output      logic                      busy,
   input  wire mbh_pkg::req_type          req_data,
   output      logic                      rsp_valid,
   output      mbh_pkg::rsp_type          rsp_data,
   input  wire logic                      csr_valid,
   output      logic                      csr_ready,
   input  wire logic [mbh_pkg::CsrIdxW-1:0] csr_index,
   input  wire logic [31:0]               csr_wdata
);
   import mbh_pkg::*;

   localparam int unsigned CW = $clog2(GRID_W);
   localparam int unsigned RW = $clog2(GRID_H);
   localparam int unsigned AW = $clog2(GRID_W * GRID_H);
   localparam int unsigned CELLS = GRID_W * GRID_H;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SQ_RR, S_SQ_II, S_SQ_RI, S_CHECK, S_UPD,
      S_MX, S_MY, S_IDX, S_RMW, S_WR, S_RD, S_RD2
   } state_type;

   state_type          state_ff;
   cfg_type            cfg_ff;
   req_type            req_ff;
   logic signed [31:0] zre_ff, zim_ff;
   logic [16:0]        it_ff;
   logic [65:0]        rr_ff, ii_ff;
   logic [AW:0]        clr_ff;
   logic [CW-1:0]      col_ff;
   logic [RW-1:0]      row_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   mul_op_type          mop;
   logic signed [32:0]  ma, mb;
   logic signed [65:0]  mp;

   // product of the operands selected in one state is seen in mp in the next
   always_comb begin
      unique case (state_ff)
         S_SQ_RR: mop = MUL_RR;
         S_SQ_II: mop = MUL_II;
         S_SQ_RI: mop = MUL_RI;
         S_MX:    mop = MUL_X;
         S_MY:    mop = MUL_Y;
         default: mop = MUL_RR;
      endcase
      unique case (mop)
         MUL_II: begin ma = 33'(zim_ff); mb = 33'(zim_ff); end
         MUL_RI: begin ma = 33'(zre_ff); mb = 33'(zim_ff); end
         MUL_X: begin
            ma = 33'($signed(zre_ff)) - 33'($signed(cfg_ff.left_bound));
            mb = $signed({1'b0, cfg_ff.x_scale});
         end
         MUL_Y: begin
            ma = 33'($signed(zim_ff)) - 33'($signed(cfg_ff.bottom_bound));
            mb = $signed({1'b0, cfg_ff.y_scale});
         end
         default: begin ma = 33'(zre_ff); mb = 33'(zre_ff); end
      endcase
   end

   mbh_mul u_mul (.clock(clock), .a(ma), .b(mb), .p_ff(mp));

   // index from unsigned d*scale >> 44 with clamp
   function automatic logic [15:0] coord(input logic [65:0] p, input int unsigned n);
      logic [21:0] k;
      k = p[65:44];
      if (k > 22'(n - 1)) k = 22'(n - 1);
      return k[15:0];
   endfunction

   logic          m_rd_en, m_wr_en;
   logic [AW-1:0] m_rd_addr, m_wr_addr, cell_addr;
   logic [95:0]   m_rd_data, m_wr_data;

   assign cell_addr = AW'(32'(row_ff) * GRID_W + 32'(col_ff));

   mbh_hist #(.AW(AW)) u_hist (
      .clock(clock), .rd_en(m_rd_en), .rd_addr(m_rd_addr), .rd_data_ff(m_rd_data),
      .wr_en(m_wr_en), .wr_addr(m_wr_addr), .wr_data(m_wr_data)
   );

   logic rd_in_grid;
   assign rd_in_grid = (32'(req_ff.cell_col) < GRID_W) && (32'(req_ff.cell_row) < GRID_H);

   always_comb begin
      m_rd_en   = (state_ff == S_RMW) || (state_ff == S_RD);
      m_rd_addr = (state_ff == S_RD)
                  ? AW'(32'(req_ff.cell_row) * GRID_W + 32'(req_ff.cell_col))
                  : cell_addr;
      m_wr_en   = (state_ff == S_CLEAR) || (state_ff == S_WR);
      m_wr_addr = (state_ff == S_CLEAR) ? clr_ff[AW-1:0] : cell_addr;
      m_wr_data = '0;
      if (state_ff == S_WR) begin
         m_wr_data[95:64] = (m_rd_data[95:64] == 32'hFFFFFFFF) ? m_rd_data[95:64]
                            : m_rd_data[95:64] + 32'd1;
         m_wr_data[63:32] = zre_ff;
         m_wr_data[31:0]  = zim_ff;
      end
   end

   // next z from the stored squares and the re*im product in mp
   logic signed [65:0] sq;
   logic signed [39:0] nre, nim;
   assign sq  = $signed(rr_ff) - $signed(ii_ff);
   assign nre = 40'($signed(sq[65:Frac]))   + 40'(req_ff.c_re);
   assign nim = 40'($signed(mp[65:Frac-1])) + 40'(req_ff.c_im);

   logic signed [31:0] nzre, nzim;
   assign nzre = sat32(nre);
   assign nzim = sat32(nim);

   logic esc_hit, lim_hit, rsp_valid_in;
   assign esc_hit = (rr_ff + ii_ff >= (66'd4 << 56));
   assign lim_hit = (it_ff > 17'(cfg_ff.max_iter));
   assign rsp_valid_in = !reset && (((state_ff == S_CHECK) && (esc_hit || lim_hit))
                                    || (state_ff == S_RD2));

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff != S_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      rsp_valid_ff <= rsp_valid_in;
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         cfg_ff.left_bound   <= -32'sd536870912;
         cfg_ff.right_bound  <= 32'sd536870912;
         cfg_ff.bottom_bound <= -32'sd429496730;
         cfg_ff.top_bound    <= 32'sd429496730;
         cfg_ff.x_scale      <= 32'd8388608;
         cfg_ff.y_scale      <= 32'd10485760;
         cfg_ff.max_iter     <= 16'd100;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_idx_type'(csr_index))
               CSR_LEFT:   cfg_ff.left_bound   <= csr_wdata;
               CSR_RIGHT:  cfg_ff.right_bound  <= csr_wdata;
               CSR_BOTTOM: cfg_ff.bottom_bound <= csr_wdata;
               CSR_TOP:    cfg_ff.top_bound    <= csr_wdata;
               CSR_XSCALE: cfg_ff.x_scale      <= csr_wdata;
               CSR_YSCALE: cfg_ff.y_scale      <= csr_wdata;
               CSR_MAXIT:  cfg_ff.max_iter     <= csr_wdata[15:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (AW+1)'(CELLS - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (start) begin
                  req_ff <= req_data;
                  zre_ff <= '0;
                  zim_ff <= '0;
                  it_ff  <= '0;
                  state_ff <= (req_data.cmd == CMD_READ) ? S_RD : S_SQ_RR;
               end
            end
            S_SQ_RR: state_ff <= S_SQ_II;
            S_SQ_II: begin rr_ff <= mp; state_ff <= S_SQ_RI; end
            S_SQ_RI: begin ii_ff <= mp; state_ff <= S_CHECK; end
            S_CHECK: begin
               // mp holds re*im now; escape test on |z|^2
               if (esc_hit) begin
                  rsp_ff <= '{steps: it_ff, escaped: (it_ff <= 17'(cfg_ff.max_iter)),
                              hit_count: '0, last_re: '0, last_im: '0};
                  state_ff <= S_IDLE;
               end else if (lim_hit) begin
                  rsp_ff <= '{steps: it_ff, escaped: 1'b0,
                              hit_count: '0, last_re: '0, last_im: '0};
                  state_ff <= S_IDLE;
               end else begin
                  zre_ff <= nzre;
                  zim_ff <= nzim;
                  it_ff  <= it_ff + 1'b1;
                  state_ff <= S_UPD;
               end
            end
            S_UPD: begin
               if (it_ff != 17'd1 && zre_ff > cfg_ff.left_bound && zre_ff < cfg_ff.right_bound
                   && zim_ff < cfg_ff.top_bound && zim_ff > cfg_ff.bottom_bound)
                  state_ff <= S_MX;
               else
                  state_ff <= S_SQ_RR;
            end
            S_MX: state_ff <= S_MY;
            S_MY: begin
               col_ff <= CW'(coord(mp, GRID_W));
               state_ff <= S_IDX;
            end
            S_IDX: begin
               row_ff <= RW'(coord(mp, GRID_H));
               state_ff <= S_RMW;
            end
            S_RMW: state_ff <= S_WR;
            S_WR: state_ff <= S_SQ_RR;
            S_RD: state_ff <= S_RD2;
            S_RD2: begin
               rsp_ff <= '{steps: '0, escaped: 1'b0,
                           hit_count: rd_in_grid ? m_rd_data[95:64] : '0,
                           last_re:   rd_in_grid ? m_rd_data[63:32] : '0,
                           last_im:   rd_in_grid ? m_rd_data[31:0]  : '0};
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_rsp_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double result");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_read_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit_count != 0 |-> rsp_data.steps == 0)
      else $error("read with steps");
`endif
endmodule
`default_nettype wire

// ----- design/mbh_mul.sv -----
`default_nettype none
module mbh_mul (
   input  wire logic                clock,
   input  wire logic signed [32:0]  a,
   input  wire logic signed [32:0]  b,
   output      logic signed [65:0]  p_ff
);
   import mbh_pkg::*;
   always_ff @(posedge clock) begin
      p_ff <= a * b;
   end
endmodule
`default_nettype wire

// ----- design/mbh_hist.sv -----
`default_nettype none
module mbh_hist #(
   parameter int unsigned AW = 18
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output      logic [95:0]   rd_data_ff,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [95:0]   wr_data
);
   import mbh_pkg::*;
   logic [95:0] mem [0:(1<<AW)-1];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end
endmodule
`default_nettype wire
